// File: rtl/lptt_pkg.sv
// Shared types and constants for the load pair training table.
// Used by the front, back and core modules and the testbench; depends on nothing else.
package lptt_pkg;

	localparam int NUM_SETS    = 64;
	localparam int NUM_WAYS    = 8;
	localparam int SET_W       = $clog2(NUM_SETS);
	localparam int WAY_W       = $clog2(NUM_WAYS);
	localparam int TREE_LEVELS = (NUM_WAYS > 4) ? 3 : 2;
	localparam int TREE_LEAVES = 1 << TREE_LEVELS;
	localparam int PLRU_W      = 7;
	localparam int PC_W        = 48;
	localparam int META_W      = 15;
	localparam int CNT_W       = 32;
	localparam int CFG_W       = 16;

	typedef enum logic [1:0] {
		CFG_TRAIN_ENABLE  = 2'd0,
		CFG_INSERT_THRESH = 2'd1,
		CFG_TAG_BITS      = 2'd2,
		CFG_INDEX_BITS    = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		OUT_IGNORED   = 2'd0,
		OUT_COUNTED   = 2'd1,
		OUT_REINFORCE = 2'd2,
		OUT_PROMOTE   = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [47:0] first_pc;
		logic [47:0] second_pc;
		logic [63:0] first_address;
		logic [63:0] second_address;
		logic [7:0]  second_size;
		logic [7:0]  first_uop;
		logic [7:0]  second_uop;
		logic [5:0]  core_id;
		logic        retrain;
	} in_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic [47:0] pair_first_pc;
		logic [47:0] pair_second_pc;
		logic [63:0] pair_first_address;
		logic [63:0] pair_second_address;
		logic [5:0]  offset_gap;
		logic        gap_upward;
		logic [7:0]  pair_size;
		logic [7:0]  pair_first_uop;
		logic [7:0]  pair_second_uop;
		logic [5:0]  pair_core;
		logic [31:0] seen_count;
	} out_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic              ignore;
		logic [SET_W-1:0]  set;
		logic [PC_W-1:0]   tag1;
		logic [PC_W-1:0]   tag2;
		logic [META_W-1:0] meta;
		in_t               req;
	} cls_t;

	typedef struct packed {
		logic [PC_W-1:0]   tag1;
		logic [PC_W-1:0]   tag2;
		logic [META_W-1:0] meta;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

	typedef entry_t [NUM_WAYS-1:0] row_t;

	// One set as stored in the row memory: way valid bits, PLRU tree and the ways.
	typedef struct packed {
		logic [NUM_WAYS-1:0] valid;
		logic [PLRU_W-1:0]   plru;
		row_t                ways;
	} set_row_t;

endpackage

// File: rtl/lptt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/lptt_front.sv
// Front end: accepts load pairs, classifies them and queues the requests.
// Depends on lptt_pkg.
module lptt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lptt_pkg::in_t        in_data,
	input  logic                 train_enable,
	input  logic [5:0]           tag_bits,
	input  logic [5:0]           index_bits,
	output logic                 q_valid,
	input  logic                 q_pop,
	output lptt_pkg::cls_t       q_data
);
	function automatic logic [47:0] upper_pc(logic [47:0] pc, logic [5:0] bits);
		logic [5:0] sh;
		begin
			sh = 6'd48 - bits;
			if (bits >= 6'd48) begin
				upper_pc = pc;
			end else begin
				upper_pc = pc >> sh;
			end
		end
	endfunction

	logic [5:0]  off1, off2, gap;
	logic        up;
	logic [47:0] ia, ib;
	logic [63:0] m0, m1, m2, m3;
	lptt_pkg::cls_t cls;

	always_comb begin
		off1 = in_data.first_address[5:0];
		off2 = in_data.second_address[5:0];
		up   = (off2 >= off1);
		gap  = up ? (off2 - off1) : (off1 - off2);
		ia   = upper_pc(in_data.first_pc, index_bits);
		ib   = upper_pc(in_data.second_pc, index_bits);
		m0   = {16'd0, ia} ^ ({16'd0, ib} << 17) ^ ({16'd0, ib} >> 15)
			^ ({58'd0, gap} << 6) ^ ({63'd0, up} << 12)
			^ ({56'd0, in_data.second_size} << 13);
		m1   = m0 ^ (m0 >> 32);
		m2   = m1 ^ (m1 >> 16);
		m3   = m2 ^ (m2 >> 8);
		cls.ignore = !train_enable || (in_data.first_pc == '0)
			|| (in_data.second_pc == '0) || (in_data.second_size == '0);
		cls.set  = m3[lptt_pkg::SET_W-1:0];
		cls.tag1 = upper_pc(in_data.first_pc, tag_bits);
		cls.tag2 = upper_pc(in_data.second_pc, tag_bits);
		cls.meta = {in_data.second_size, up, gap};
		cls.req  = in_data;
	end

	// Two-entry request queue.
	lptt_pkg::cls_t slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// File: rtl/lptt_back.sv
// Back end: reset clearing of the rows, set lookup, fill, PLRU update, counting and the result register.
// Depends on lptt_pkg and lptt_ram.
module lptt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  lptt_pkg::cls_t       q_data,
	input  logic [15:0]          threshold,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lptt_pkg::out_t       out_data
);
	localparam int NW = lptt_pkg::NUM_WAYS;
	localparam int WW = lptt_pkg::WAY_W;
	localparam int TL = lptt_pkg::TREE_LEVELS;
	localparam int SW = lptt_pkg::SET_W;

	function automatic logic [6:0] plru_touch(logic [6:0] bits, logic [WW-1:0] way);
		logic [2:0]    n;
		logic [TL-1:0] w;
		logic          d;
		begin
			n = 3'd0;
			w = TL'(way);
			for (int lvl = 0; lvl < TL; lvl++) begin
				d = w[TL-1-lvl];
				bits[n] = !d;
				n = 3'((2 * n) + 1) + {2'd0, d};
			end
			plru_touch = bits;
		end
	endfunction

	function automatic logic [WW-1:0] plru_victim(logic [6:0] bits);
		logic [3:0] n;
		logic [3:0] w;
		begin
			n = 4'd0;
			for (int lvl = 0; lvl < TL; lvl++) begin
				n = 4'((2 * n) + 1) + {3'd0, bits[n[2:0]]};
			end
			w = n - 4'(lptt_pkg::TREE_LEAVES - 1);
			if (w >= 4'(NW)) begin
				w = 4'(NW - 1);
			end
			plru_victim = w[WW-1:0];
		end
	endfunction

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_LOOK} bstate_t;

	bstate_t            state_q;
	logic [SW-1:0]      clr_q;
	lptt_pkg::cls_t     cur_s1;
	lptt_pkg::set_row_t rd_row, wr_row, ram_wdata;
	logic [SW-1:0]      ram_waddr;
	logic               out_free, rd_en, wr_en, out_load;

	assign out_free  = !out_valid || !out_stall;
	assign q_pop     = (state_q == B_IDLE) && q_valid && out_free;
	assign rd_en     = q_pop && !q_data.ignore;
	assign wr_en     = (state_q == B_LOOK) || (state_q == B_CLEAR);
	assign ram_waddr = (state_q == B_CLEAR) ? clr_q : cur_s1.set;
	assign ram_wdata = (state_q == B_CLEAR) ? '0 : wr_row;
	assign out_load  = (q_pop && q_data.ignore) || (state_q == B_LOOK);

	lptt_ram #(
		.WIDTH($bits(lptt_pkg::set_row_t)),
		.DEPTH(lptt_pkg::NUM_SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(q_data.set),
		.rdata(rd_row)
	);

	// Way lookup on the row read in the previous cycle.
	logic [NW-1:0]    vrow;
	logic             hit_f, inv_f;
	logic [WW-1:0]    hit_w, inv_w, sel_w;
	logic [31:0]      cnt_old, cnt_new;
	logic [16:0]      thr;
	logic [1:0]       outc;
	lptt_pkg::entry_t new_e;

	always_comb begin
		vrow  = rd_row.valid;
		hit_f = 1'b0;
		inv_f = 1'b0;
		hit_w = '0;
		inv_w = '0;
		for (int w = 0; w < NW; w++) begin
			if (vrow[w]) begin
				if (!hit_f && rd_row.ways[w].tag1 == cur_s1.tag1
					&& rd_row.ways[w].tag2 == cur_s1.tag2
					&& rd_row.ways[w].meta == cur_s1.meta) begin
					hit_f = 1'b1;
					hit_w = WW'(w);
				end
			end else if (!inv_f) begin
				inv_f = 1'b1;
				inv_w = WW'(w);
			end
		end
		if (hit_f) begin
			sel_w = hit_w;
		end else if (inv_f) begin
			sel_w = inv_w;
		end else begin
			sel_w = plru_victim(rd_row.plru);
		end
		cnt_old = hit_f ? rd_row.ways[sel_w].cnt : 32'd0;
		cnt_new = (cnt_old == 32'hFFFF_FFFF) ? cnt_old : cnt_old + 32'd1;
		thr     = (threshold == 16'd0) ? 17'd1 : {1'b0, threshold};
		if (cnt_new < {15'd0, thr}) begin
			outc = lptt_pkg::OUT_COUNTED;
		end else if (cnt_new > {15'd0, thr} && !cur_s1.req.retrain) begin
			outc = lptt_pkg::OUT_REINFORCE;
		end else begin
			outc = lptt_pkg::OUT_PROMOTE;
		end
		new_e.tag1 = cur_s1.tag1;
		new_e.tag2 = cur_s1.tag2;
		new_e.meta = cur_s1.meta;
		new_e.cnt  = cnt_new;
		wr_row              = rd_row;
		wr_row.ways[sel_w]  = new_e;
		wr_row.valid[sel_w] = 1'b1;
		wr_row.plru         = plru_touch(rd_row.plru, sel_w);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_s1 <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
		end else begin
			out_valid <= out_load || (out_valid && out_stall);
			unique case (state_q)
				B_CLEAR: begin
					// Zero one row per cycle so every set starts empty.
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(lptt_pkg::NUM_SETS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_pop) begin
						if (q_data.ignore) begin
							out_data <= '0;
						end else begin
							state_q <= B_LOOK;
						end
					end
				end
				B_LOOK: begin
					out_data.outcome             <= outc;
					out_data.pair_first_pc       <= cur_s1.req.first_pc;
					out_data.pair_second_pc      <= cur_s1.req.second_pc;
					out_data.pair_first_address  <= cur_s1.req.first_address;
					out_data.pair_second_address <= cur_s1.req.second_address;
					out_data.offset_gap          <= cur_s1.meta[5:0];
					out_data.gap_upward          <= cur_s1.meta[6];
					out_data.pair_size           <= cur_s1.req.second_size;
					out_data.pair_first_uop      <= cur_s1.req.first_uop;
					out_data.pair_second_uop     <= cur_s1.req.second_uop;
					out_data.pair_core           <= cur_s1.req.core_id;
					out_data.seen_count          <= cnt_new;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/load_pair_training_table_core.sv
// Load pair training table: 64-set, 8-way confidence table with tree PLRU.
// A request waits in the queue until the back end is idle and the result register free;
// its row is then read, looked up and written back while the result is registered, and
// no new request is popped until that write; an ignored request skips the row memory.
// Reset: configuration returns to enable 1, threshold 4, tag and index widths 48; a
// clearing pass then zeroes every row, and requests wait in the queue meanwhile.
module load_pair_training_table_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lptt_pkg::in_t        in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lptt_pkg::out_t       out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	logic        enable_q;
	logic [15:0] thresh_q;
	logic [5:0]  tag_bits_q, index_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b1;
			thresh_q     <= 16'd4;
			tag_bits_q   <= 6'd48;
			index_bits_q <= 6'd48;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lptt_pkg::CFG_TRAIN_ENABLE:  enable_q     <= cfg_data[0];
				lptt_pkg::CFG_INSERT_THRESH: thresh_q     <= cfg_data;
				lptt_pkg::CFG_TAG_BITS:      tag_bits_q   <= cfg_data[5:0];
				lptt_pkg::CFG_INDEX_BITS:    index_bits_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	logic           q_valid, q_pop;
	lptt_pkg::cls_t q_data;

	lptt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.train_enable(enable_q),
		.tag_bits    (tag_bits_q),
		.index_bits  (index_bits_q),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_data)
	);

	lptt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data),
		.threshold(thresh_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);
endmodule

// File: test/tb_top.sv
// Self-checking testbench for load_pair_training_table_core: directed table plus random pairs.
// A behavioral copy of the training table predicts each result; depends on lptt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	lptt_pkg::in_t in_data;
	logic out_valid;
	logic out_stall;
	lptt_pkg::out_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	load_pair_training_table_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [47:0] tag1_mem [lptt_pkg::NUM_SETS*lptt_pkg::NUM_WAYS];
	logic [47:0] tag2_mem [lptt_pkg::NUM_SETS*lptt_pkg::NUM_WAYS];
	logic [14:0] meta_mem [lptt_pkg::NUM_SETS*lptt_pkg::NUM_WAYS];
	logic [31:0] count_mem [lptt_pkg::NUM_SETS*lptt_pkg::NUM_WAYS];
	logic valid_mem [lptt_pkg::NUM_SETS*lptt_pkg::NUM_WAYS];
	logic [6:0] tree_mem [lptt_pkg::NUM_SETS];
	logic p_enable;
	logic [15:0] p_threshold;
	logic [5:0] p_tag_bits;
	logic [5:0] p_index_bits;

	lptt_pkg::out_t pending_results [$];
	int errors;

	// Directed rows; has_exp marks rows whose result is typed in.
	typedef struct {
		lptt_pkg::in_t req;
		logic has_exp;
		lptt_pkg::out_t exp;
	} drow_t;

	function automatic logic [47:0] pc_upper(logic [47:0] pc, logic [5:0] bits);
		if (bits >= 48)
			return pc;
		return pc >> (48 - bits);
	endfunction

	function automatic int unsigned fold_set(logic [47:0] pc1, logic [47:0] pc2,
		logic [5:0] gap, logic up, logic [7:0] size);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] m;
		a = {16'd0, pc_upper(pc1, p_index_bits)};
		b = {16'd0, pc_upper(pc2, p_index_bits)};
		m = a ^ (b << 17) ^ (b >> 15);
		m ^= {58'd0, gap} << 6;
		if (up)
			m ^= 64'd1 << 12;
		m ^= {56'd0, size} << 13;
		m ^= m >> 32;
		m ^= m >> 16;
		m ^= m >> 8;
		return 32'(m & 64'(lptt_pkg::NUM_SETS - 1));
	endfunction

	function automatic int unsigned tree_victim(int unsigned set);
		int unsigned n;
		int unsigned way;
		n = 0;
		for (int lvl = 0; lvl < lptt_pkg::TREE_LEVELS; lvl++)
			n = 2 * n + 1 + tree_mem[set][n];
		way = n - (lptt_pkg::TREE_LEAVES - 1);
		if (way >= lptt_pkg::NUM_WAYS)
			way = lptt_pkg::NUM_WAYS - 1;
		return way;
	endfunction

	function automatic void tree_touch(int unsigned set, int unsigned way);
		int unsigned n;
		int unsigned d;
		n = 0;
		for (int lvl = 0; lvl < lptt_pkg::TREE_LEVELS; lvl++) begin
			d = (way >> (lptt_pkg::TREE_LEVELS - 1 - lvl)) & 1;
			tree_mem[set][n] = (d == 0);
			n = 2 * n + 1 + d;
		end
	endfunction

	function automatic lptt_pkg::out_t train_pair(lptt_pkg::in_t r);
		lptt_pkg::out_t o;
		logic [5:0] off1;
		logic [5:0] off2;
		logic [5:0] gap;
		logic up;
		logic [14:0] meta;
		logic [47:0] t1;
		logic [47:0] t2;
		logic [31:0] cnt;
		logic [31:0] thr;
		int unsigned set;
		int unsigned base;
		int unsigned hit;
		int unsigned inv;
		o = '0;
		if (!p_enable || r.first_pc == 0 || r.second_pc == 0 || r.second_size == 0)
			return o;
		off1 = r.first_address[5:0];
		off2 = r.second_address[5:0];
		up = off2 >= off1;
		gap = up ? off2 - off1 : off1 - off2;
		meta = {r.second_size, up, gap};
		set = fold_set(r.first_pc, r.second_pc, gap, up, r.second_size);
		t1 = pc_upper(r.first_pc, p_tag_bits);
		t2 = pc_upper(r.second_pc, p_tag_bits);
		base = set * lptt_pkg::NUM_WAYS;
		hit = lptt_pkg::NUM_WAYS;
		inv = lptt_pkg::NUM_WAYS;
		for (int w = 0; w < lptt_pkg::NUM_WAYS; w++) begin
			if (valid_mem[base + w]) begin
				if (hit == lptt_pkg::NUM_WAYS && tag1_mem[base + w] == t1 &&
					tag2_mem[base + w] == t2 && meta_mem[base + w] == meta)
					hit = w;
			end else if (inv == lptt_pkg::NUM_WAYS && hit == lptt_pkg::NUM_WAYS) begin
				inv = w;
			end
		end
		if (hit == lptt_pkg::NUM_WAYS) begin
			hit = (inv < lptt_pkg::NUM_WAYS) ? inv : tree_victim(set);
			tag1_mem[base + hit] = t1;
			tag2_mem[base + hit] = t2;
			meta_mem[base + hit] = meta;
			count_mem[base + hit] = 0;
			valid_mem[base + hit] = 1;
		end
		tree_touch(set, hit);
		cnt = count_mem[base + hit];
		if (cnt != 32'hFFFFFFFF)
			cnt++;
		count_mem[base + hit] = cnt;
		thr = (p_threshold == 0) ? 32'd1 : {16'd0, p_threshold};
		if (cnt < thr)
			o.outcome = lptt_pkg::OUT_COUNTED;
		else if (cnt > thr && !r.retrain)
			o.outcome = lptt_pkg::OUT_REINFORCE;
		else
			o.outcome = lptt_pkg::OUT_PROMOTE;
		o.pair_first_pc = r.first_pc;
		o.pair_second_pc = r.second_pc;
		o.pair_first_address = r.first_address;
		o.pair_second_address = r.second_address;
		o.offset_gap = gap;
		o.gap_upward = up;
		o.pair_size = r.second_size;
		o.pair_first_uop = r.first_uop;
		o.pair_second_uop = r.second_uop;
		o.pair_core = r.core_id;
		o.seen_count = cnt;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("load_pair_training_table_core regression: fail");
		$finish;
	end

	// Result side: random stall and compare with the oldest expectation.
	initial begin
		int gap_cycles;
		lptt_pkg::out_t want;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			out_stall = (gap_cycles != 0);
			repeat (gap_cycles) @(negedge clk);
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(out_data.outcome), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.outcome != want.outcome)
					report_mismatch("outcome", 64'(out_data.outcome), 64'(want.outcome));
				if (out_data.pair_first_pc != want.pair_first_pc)
					report_mismatch("pair_first_pc", 64'(out_data.pair_first_pc),
						64'(want.pair_first_pc));
				if (out_data.pair_second_pc != want.pair_second_pc)
					report_mismatch("pair_second_pc", 64'(out_data.pair_second_pc),
						64'(want.pair_second_pc));
				if (out_data.pair_first_address != want.pair_first_address)
					report_mismatch("pair_first_address", out_data.pair_first_address,
						want.pair_first_address);
				if (out_data.pair_second_address != want.pair_second_address)
					report_mismatch("pair_second_address", out_data.pair_second_address,
						want.pair_second_address);
				if (out_data.offset_gap != want.offset_gap)
					report_mismatch("offset_gap", 64'(out_data.offset_gap),
						64'(want.offset_gap));
				if (out_data.gap_upward != want.gap_upward)
					report_mismatch("gap_upward", 64'(out_data.gap_upward),
						64'(want.gap_upward));
				if (out_data.pair_size != want.pair_size)
					report_mismatch("pair_size", 64'(out_data.pair_size), 64'(want.pair_size));
				if (out_data.pair_first_uop != want.pair_first_uop)
					report_mismatch("pair_first_uop", 64'(out_data.pair_first_uop),
						64'(want.pair_first_uop));
				if (out_data.pair_second_uop != want.pair_second_uop)
					report_mismatch("pair_second_uop", 64'(out_data.pair_second_uop),
						64'(want.pair_second_uop));
				if (out_data.pair_core != want.pair_core)
					report_mismatch("pair_core", 64'(out_data.pair_core), 64'(want.pair_core));
				if (out_data.seen_count != want.seen_count)
					report_mismatch("seen_count", 64'(out_data.seen_count),
						64'(want.seen_count));
			end
		end
	end

	// Sends one request after a random gap; the prediction is made when it is accepted.
	// Valid stays high after acceptance until the next gap or the caller lowers it.
	task automatic send_request(lptt_pkg::in_t r, logic has_exp, lptt_pkg::out_t exp);
		int gap_cycles;
		lptt_pkg::out_t pred;
		gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		if (gap_cycles != 0) begin
			in_valid <= 0;
			repeat (gap_cycles) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		pred = train_pair(r);
		if (has_exp && pred != exp)
			report_mismatch("typed expectation", 64'(pred.outcome), 64'(exp.outcome));
		pending_results.push_back(has_exp ? exp : pred);
		@(negedge clk);
	endtask

	task automatic write_register(lptt_pkg::cfg_index_t idx, logic [15:0] value);
		in_valid <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			lptt_pkg::CFG_TRAIN_ENABLE:  p_enable = value[0];
			lptt_pkg::CFG_INSERT_THRESH: p_threshold = value;
			lptt_pkg::CFG_TAG_BITS:      p_tag_bits = value[5:0];
			default:                     p_index_bits = value[5:0];
		endcase
	endtask

	// Random pair drawn from a small pool so that entries are hit again and again.
	function automatic lptt_pkg::in_t random_pair(int unsigned pool);
		lptt_pkg::in_t r;
		int unsigned k;
		k = $urandom_range(0, pool);
		r.first_pc = 48'({$urandom, $urandom});
		r.second_pc = 48'({$urandom, $urandom});
		r.first_address = {$urandom, $urandom};
		r.second_address = {$urandom, $urandom};
		r.second_size = 8'($urandom);
		r.first_uop = 8'($urandom);
		r.second_uop = 8'($urandom);
		r.core_id = 6'($urandom);
		r.retrain = ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 9) != 0) begin
			// Well-formed repeats: first PC and offsets fixed per pool slot, second PC one of two per slot.
			r.first_pc = 48'h4000_0000_0000 + 48'(k) * 48'h1_0000_0040;
			r.second_pc = {$urandom_range(0, 1) ? 8'hFF : 8'h01, 40'(k * 48'h33)};
			r.first_address[5:0] = 6'(k * 5);
			r.second_address[5:0] = 6'(k * 11);
			r.second_size = 8'(1 << (k % 4));
		end else begin
			case ($urandom_range(0, 3))
				0: r.first_pc = 0;
				1: r.second_pc = 0;
				2: r.second_size = 0;
				default: ;
			endcase
		end
		return r;
	endfunction

	initial begin
		drow_t rows [$];
		drow_t evict_rows [$];
		drow_t d;
		lptt_pkg::in_t r;
		lptt_pkg::out_t z;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = lptt_pkg::CFG_TRAIN_ENABLE;
		cfg_data = '0;
		errors = 0;
		p_enable = 1;
		p_threshold = 4;
		p_tag_bits = 48;
		p_index_bits = 48;
		for (int i = 0; i < lptt_pkg::NUM_SETS * lptt_pkg::NUM_WAYS; i++)
			valid_mem[i] = 0;
		for (int i = 0; i < lptt_pkg::NUM_SETS; i++)
			tree_mem[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed table: drops, extremes, repeats through threshold, retrain.
		z = '0;
		r = '0;
		r.second_pc = 48'h1234; r.second_size = 8'd4;
		d.req = r; d.has_exp = 1; d.exp = z; rows.push_back(d);
		r = '1; r.second_size = 0;
		d.req = r; d.has_exp = 1; d.exp = z; rows.push_back(d);
		r = '1; r.second_pc = 0;
		d.req = r; d.has_exp = 1; d.exp = z; rows.push_back(d);
		// All-ones pair: same offsets, upward gap zero, first sight counts once.
		r = '1; r.retrain = 0;
		d.req = r; d.has_exp = 1; d.exp = '0;
		d.exp.outcome = lptt_pkg::OUT_COUNTED;
		d.exp.pair_first_pc = '1; d.exp.pair_second_pc = '1;
		d.exp.pair_first_address = '1; d.exp.pair_second_address = '1;
		d.exp.gap_upward = 1; d.exp.pair_size = 8'hFF;
		d.exp.pair_first_uop = 8'hFF; d.exp.pair_second_uop = 8'hFF;
		d.exp.pair_core = 6'h3F; d.exp.seen_count = 1;
		rows.push_back(d);
		d.has_exp = 0;
		for (int i = 0; i < 7; i++) begin
			r = '0;
			r.first_pc = 48'h8000_0000_0001; r.second_pc = 48'h0000_0000_0100;
			r.first_address = 64'h3F; r.second_address = 64'hFFFF_0000_0000_0000;
			r.second_size = 8'd8; r.first_uop = 8'(i); r.core_id = 6'(i);
			r.retrain = (i == 5);
			d.req = r; rows.push_back(d);
		end
		foreach (rows[i])
			send_request(rows[i].req, rows[i].has_exp, rows[i].exp);

		// Ten distinct pairs with index width zero and equal metadata share one set,
		// so both rounds force evictions and PLRU victims.
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < 10; i++) begin
				r = '0;
				r.first_pc = 48'h1 + 48'(i); r.second_pc = 48'h2;
				r.first_address = 64'h10; r.second_address = 64'h20;
				r.second_size = 8'h80;
				d.req = r; evict_rows.push_back(d);
			end
		end
		write_register(lptt_pkg::CFG_INDEX_BITS, 16'd0);
		foreach (evict_rows[i])
			send_request(evict_rows[i].req, evict_rows[i].has_exp, evict_rows[i].exp);
		write_register(lptt_pkg::CFG_INDEX_BITS, 16'd48);

		write_register(lptt_pkg::CFG_TRAIN_ENABLE, 16'd0);
		r = '1;
		send_request(r, 1, z);
		write_register(lptt_pkg::CFG_TRAIN_ENABLE, 16'd1);

		// Random phases across register settings, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_register(lptt_pkg::CFG_INSERT_THRESH, 16'd0);
					write_register(lptt_pkg::CFG_TAG_BITS, 16'd1);
					write_register(lptt_pkg::CFG_INDEX_BITS, 16'd1); end
				1: begin write_register(lptt_pkg::CFG_INSERT_THRESH, 16'd2);
					write_register(lptt_pkg::CFG_TAG_BITS, 16'd63);
					write_register(lptt_pkg::CFG_INDEX_BITS, 16'd48); end
				2: begin write_register(lptt_pkg::CFG_INSERT_THRESH, 16'hFFFF);
					write_register(lptt_pkg::CFG_TAG_BITS, 16'd0);
					write_register(lptt_pkg::CFG_INDEX_BITS, 16'd0); end
				3: begin write_register(lptt_pkg::CFG_INSERT_THRESH, 16'd3);
					write_register(lptt_pkg::CFG_TAG_BITS, 16'd12);
					write_register(lptt_pkg::CFG_INDEX_BITS, 16'd20); end
				4: begin write_register(lptt_pkg::CFG_INSERT_THRESH, 16'd1);
					write_register(lptt_pkg::CFG_TAG_BITS, 16'd48);
					write_register(lptt_pkg::CFG_INDEX_BITS, 16'd63); end
				default: begin write_register(lptt_pkg::CFG_INSERT_THRESH, 16'd5);
					write_register(lptt_pkg::CFG_TAG_BITS, 16'd40);
					write_register(lptt_pkg::CFG_INDEX_BITS, 16'd6); end
			endcase
			for (int i = 0; i < 150; i++)
				send_request(random_pair((ph % 2) ? 40 : 12), 0, z);
		end
		in_valid <= 0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("load_pair_training_table_core regression: pass");
		else
			$display("load_pair_training_table_core regression: fail");
		$finish;
	end

endmodule

// File: load_pair_training_table_core.f
rtl/lptt_pkg.sv
rtl/lptt_ram.sv
rtl/lptt_front.sv
rtl/lptt_back.sv
rtl/load_pair_training_table_core.sv
test/tb_top.sv
